FILE: design/serial_time_set_parser_assert.svh
// Assertion macros used by the time-set parser checker.
`ifndef SERIAL_TIME_SET_PARSER_ASSERT_SVH
`define SERIAL_TIME_SET_PARSER_ASSERT_SVH

// Assert a property on the rising clock edge, disabled while reset is high.
`define STSP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assert a property on the rising clock edge with no reset qualification.
`define STSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/stsp_pkg.sv
// Types, codes and helpers for the serial time-set parser.
`default_nettype none

package stsp_pkg;

  localparam int CharW = 8;

  localparam logic [CharW-1:0] CHAR_START = 8'h54;  // 'T'
  localparam logic [CharW-1:0] CHAR_SEP   = 8'h3A;  // ':'
  localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;  // '9'

  localparam logic [6:0] HOURS_MAX  = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;

  // Parse positions through one frame
  typedef enum logic [3:0] {
    POS_START = 4'd0,
    POS_H10   = 4'd1,
    POS_H1    = 4'd2,
    POS_SEP1  = 4'd3,
    POS_M10   = 4'd4,
    POS_M1    = 4'd5,
    POS_SEP2  = 4'd6,
    POS_S10   = 4'd7,
    POS_S1    = 4'd8,
    POS_TRAIL = 4'd9
  } pos_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_SET  = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [5:0] hours_bcd;
    logic [6:0] minutes_bcd;
    logic [6:0] seconds_bcd;
  } result_t;

  // Convert a value of 0..79 to two BCD digits (tens in [6:4], units in [3:0])
  function automatic logic [6:0] to_bcd(input logic [6:0] v);
    logic [2:0] tens;
    logic [6:0] rem;
    begin
      if (v >= 7'd70) tens = 3'd7;
      else if (v >= 7'd60) tens = 3'd6;
      else if (v >= 7'd50) tens = 3'd5;
      else if (v >= 7'd40) tens = 3'd4;
      else if (v >= 7'd30) tens = 3'd3;
      else if (v >= 7'd20) tens = 3'd2;
      else if (v >= 7'd10) tens = 3'd1;
      else tens = 3'd0;
      rem = v - ({4'd0, tens} * 7'd10);
      to_bcd = {tens, rem[3:0]};
    end
  endfunction

endpackage

`default_nettype wire

FILE: design/stsp_if.sv
// Handshake channels for received characters and parsed time words.
`default_nettype none

interface stsp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface stsp_time_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] hours_bcd;
  logic [6:0] minutes_bcd;
  logic [6:0] seconds_bcd;

  modport source (output valid, output status, output hours_bcd, output minutes_bcd,
                  output seconds_bcd, input ready);
  modport sink (input valid, input status, input hours_bcd, input minutes_bcd,
                input seconds_bcd, output ready);
endinterface

`default_nettype wire

FILE: design/stsp_in_stage.sv
// Input register: captures one received character word.
`default_nettype none

module stsp_in_stage
  import stsp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [CharW-1:0] in_char,
  output logic                  in_ready,
  input  wire logic             advance,
  output logic                  valid,
  output logic [CharW-1:0]      char_q
);

  // Take a new word when empty or when the held word moves on
  assign in_ready = !valid || advance;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Hold the character
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_q <= in_char;
    end
  end

endmodule

`default_nettype wire

FILE: design/stsp_parse_core.sv
// Parser state and the per-character update and result logic.
`default_nettype none

module stsp_parse_core
  import stsp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic [CharW-1:0] char_q,
  output result_t               result
);

  pos_t       pos, pos_next;
  logic [6:0] hours_acc, hours_acc_next;
  logic [6:0] minutes_acc, minutes_acc_next;
  logic [6:0] seconds_acc, seconds_acc_next;

  logic             is_digit;
  logic [CharW-1:0] char_off;
  logic [3:0]       digit;
  logic [6:0]       digit_x10;
  logic [6:0]       digit_ext;
  logic [6:0]       sec_sum;
  logic [6:0]       hours_fin, minutes_fin, seconds_fin;
  logic [6:0]       hours_bcd_w;
  logic             err;

  // Decode the digit
  assign is_digit  = (char_q >= CHAR_ZERO) && (char_q <= CHAR_NINE);
  assign char_off  = char_q - CHAR_ZERO;
  assign digit     = is_digit ? char_off[3:0] : 4'd0;
  assign digit_ext = {3'd0, digit};
  assign digit_x10 = (digit_ext << 3) + (digit_ext << 1);

  // Finish the fields on the last seconds digit
  assign sec_sum     = seconds_acc + digit_ext;
  assign hours_fin   = (hours_acc > HOURS_MAX) ? 7'd0 : hours_acc;
  assign minutes_fin = (minutes_acc > MINSEC_MAX) ? 7'd0 : minutes_acc;
  assign seconds_fin = (sec_sum > MINSEC_MAX) ? 7'd0 : sec_sum;
  assign hours_bcd_w = to_bcd(hours_fin);

  // Next state and result for the held character
  always_comb begin
    hours_acc_next   = hours_acc;
    minutes_acc_next = minutes_acc;
    seconds_acc_next = seconds_acc;
    result           = '{status: ST_BUSY, hours_bcd: 6'd0, minutes_bcd: 7'd0,
                         seconds_bcd: 7'd0};
    err              = 1'b0;
    unique case (pos)
      POS_START: err = (char_q != CHAR_START);
      POS_SEP1, POS_SEP2: err = (char_q != CHAR_SEP);
      POS_H10: begin
        err = !is_digit;
        if (is_digit) hours_acc_next = digit_x10;
      end
      POS_H1: begin
        err = !is_digit;
        if (is_digit) hours_acc_next = hours_acc + digit_ext;
      end
      POS_M10: begin
        err = !is_digit;
        if (is_digit) minutes_acc_next = digit_x10;
      end
      POS_M1: begin
        err = !is_digit;
        if (is_digit) minutes_acc_next = minutes_acc + digit_ext;
      end
      POS_S10: begin
        err = !is_digit;
        if (is_digit) seconds_acc_next = digit_x10;
      end
      POS_S1: begin
        err = !is_digit;
        if (is_digit) begin
          hours_acc_next     = hours_fin;
          minutes_acc_next   = minutes_fin;
          seconds_acc_next   = seconds_fin;
          result.status      = ST_SET;
          result.hours_bcd   = hours_bcd_w[5:0];
          result.minutes_bcd = to_bcd(minutes_fin);
          result.seconds_bcd = to_bcd(seconds_fin);
        end
      end
      default: err = 1'b1;
    endcase
    if (err) begin
      result.status = ST_ERR;
      pos_next      = POS_START;
    end else begin
      pos_next = pos_t'(pos + 4'd1);
    end
  end

  // Advance the parse position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_START;
    end else if (advance) begin
      pos <= pos_next;
    end
  end

  // Update the field accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      hours_acc   <= 7'd0;
      minutes_acc <= 7'd0;
      seconds_acc <= 7'd0;
    end else if (advance) begin
      hours_acc   <= hours_acc_next;
      minutes_acc <= minutes_acc_next;
      seconds_acc <= seconds_acc_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/stsp_out_stage.sv
// Result register: holds one time word until the receiver takes it.
`default_nettype none

module stsp_out_stage
  import stsp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t result,
  output logic         free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_word
);

  // Free when empty or when the held word leaves this cycle
  assign free = !out_valid || out_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the result
  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= result;
    end
  end

endmodule

`default_nettype wire

FILE: design/serial_time_set_parser.sv
// Time-set frame parser for a serial character stream, top level.
//
// char_port carries one received ASCII character per word; time_port carries
// one result word per character: status (0 in progress, 1 time set,
// 2 format error) and hours, minutes and seconds in BCD, which are nonzero
// only with status 1. Frames have the form T HH:MM:SS; the character after
// a complete frame is consumed and reported as a format error.
// A character is taken into an input register, parsed from there and its
// result loaded into the output register, where it is offered to the receiver.
// One character per cycle is sustained while time_port.ready stays high:
// the parse state updates in the same cycle the result is loaded.
// Reset (synchronous, rst high) empties both registers, returns the parser
// to the start symbol and clears the field accumulators.
// When the receiver holds time_port.ready low the output register keeps its
// word, the input register fills, and char_port.ready drops after that;
// nothing is lost or repeated.
`default_nettype none

module serial_time_set_parser
  import stsp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  stsp_char_if.sink     char_port,
  stsp_time_if.source   time_port
);

  logic             held_valid;
  logic [CharW-1:0] held_char;
  logic             out_free;
  logic             advance;
  result_t          result;
  result_t          out_word;

  // Move the held character on when the result register can take it
  assign advance = held_valid && out_free;

  stsp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (char_port.valid),
    .in_char  (char_port.char_in),
    .in_ready (char_port.ready),
    .advance  (advance),
    .valid    (held_valid),
    .char_q   (held_char)
  );

  stsp_parse_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .char_q  (held_char),
    .result  (result)
  );

  stsp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .free      (out_free),
    .out_valid (time_port.valid),
    .out_ready (time_port.ready),
    .out_word  (out_word)
  );

  // Drive the result fields
  assign time_port.status      = out_word.status;
  assign time_port.hours_bcd   = out_word.hours_bcd;
  assign time_port.minutes_bcd = out_word.minutes_bcd;
  assign time_port.seconds_bcd = out_word.seconds_bcd;

endmodule

`default_nettype wire

FILE: design/stsp_checker.sv
// Port-level checks on the time-set parser and their binding.
`default_nettype none

`include "serial_time_set_parser_assert.svh"

module stsp_checker
  import stsp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] status,
  input wire logic [5:0] hours_bcd,
  input wire logic [6:0] minutes_bcd,
  input wire logic [6:0] seconds_bcd
);

  logic [21:0] time_word;
  logic        stalled;
  logic        is_set;
  logic        fields_zero;
  logic        time_legal;
  logic        status_known;
  logic        drained;

  // Gather the result word and the conditions checked on it
  assign time_word    = {status, hours_bcd, minutes_bcd, seconds_bcd};
  assign stalled      = out_valid && !out_ready;
  assign is_set       = (status == ST_SET);
  assign fields_zero  = (hours_bcd == 6'd0) && (minutes_bcd == 7'd0) && (seconds_bcd == 7'd0);
  assign time_legal   = (hours_bcd <= 6'h23) && (hours_bcd[3:0] <= 4'd9) &&
                        (minutes_bcd <= 7'h59) && (minutes_bcd[3:0] <= 4'd9) &&
                        (seconds_bcd <= 7'h59) && (seconds_bcd[3:0] <= 4'd9);
  assign status_known = (status == ST_BUSY) || (status == ST_SET) || (status == ST_ERR);
  assign drained      = !out_valid && in_ready;

  `STSP_ASSERT(a_stall_holds, clk, rst, stalled |=> out_valid && $stable(time_word), "stalled word changed")
  `STSP_ASSERT(a_fields_zero, clk, rst, out_valid && !is_set |-> fields_zero, "stray time fields")
  `STSP_ASSERT(a_time_range, clk, rst, out_valid && is_set |-> time_legal, "time out of range")
  `STSP_ASSERT(a_status_code, clk, rst, out_valid |-> status_known, "undefined status code")
  `STSP_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> drained, "busy after reset")

endmodule

bind serial_time_set_parser stsp_checker u_stsp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (char_port.ready),
  .out_valid   (time_port.valid),
  .out_ready   (time_port.ready),
  .status      (time_port.status),
  .hours_bcd   (time_port.hours_bcd),
  .minutes_bcd (time_port.minutes_bcd),
  .seconds_bcd (time_port.seconds_bcd)
);

`default_nettype wire
